// File: rtl/core/prj_pkg.sv
// shared constants for the pinhole reprojection jacobian core
package prj_pkg;

    localparam int DATA_W        = 32;
    localparam int QUAT_FRAC     = 30;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 65;   // unsigned 32 x signed 32 product
    localparam int DIFF_W        = 35;   // jacobian numerator before scaling
    localparam int QUO1_W        = 41;   // quotient bits, projection and h divides
    localparam int QUO2_W        = 32;   // quotient bits, jacobian divides
    localparam int CFG_ADDR_W    = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_X  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_Y  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 2'd3;

endpackage

// File: rtl/core/prj_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module prj_div #(
    parameter int NUM_W  = prj_pkg::PROD_W,
    parameter int QUO_W  = prj_pkg::QUO1_W,
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [NUM_W-1:0]           num,
    input  logic signed [prj_pkg::DATA_W-1:0] den,
    input  logic [SIDE_W-1:0]                 side_in,
    output logic                              out_valid,
    output logic                              quo_neg,
    output logic                              quo_ovf,
    output logic [QUO_W-1:0]                  quo_mag,
    output logic [SIDE_W-1:0]                 side_out
);
    import prj_pkg::*;

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DATA_W) ? HI_W : DATA_W;

    logic [NUM_W-1:0]  num_abs;
    logic [DATA_W-1:0] den_abs;
    logic [HI_W-1:0]   num_hi;

    logic [QUO_W:0]    vld_reg;
    logic [DATA_W-1:0] rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]  sh_reg   [QUO_W+1];
    logic [DATA_W-1:0] den_reg  [QUO_W+1];
    logic              neg_reg  [QUO_W+1];
    logic              ovf_reg  [QUO_W+1];
    logic [SIDE_W-1:0] side_reg [QUO_W+1];

    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_abs = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
    assign num_hi  = num_abs[NUM_W-1:QUO_W];

    // magnitude overflow: quotient would need more than QUO_W bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DATA_W'(num_hi);
        sh_reg[0]   <= num_abs[QUO_W-1:0];
        den_reg[0]  <= den_abs;
        neg_reg[0]  <= num[NUM_W-1] ^ den[DATA_W-1];
        ovf_reg[0]  <= CMP_W'(num_hi) >= CMP_W'(den_abs);
        side_reg[0] <= side_in;
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_step
        logic [DATA_W:0]   trial;
        logic              take;
        logic [DATA_W-1:0] rem_next;
        logic [QUO_W-1:0]  sh_next;

        assign trial    = {rem_reg[k-1], sh_reg[k-1][QUO_W-1]};
        assign take     = trial >= {1'b0, den_reg[k-1]};
        assign rem_next = take ? DATA_W'(trial - {1'b0, den_reg[k-1]}) : DATA_W'(trial);
        assign sh_next  = {sh_reg[k-1][QUO_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            sh_reg[k]   <= sh_next;
            den_reg[k]  <= den_reg[k-1];
            neg_reg[k]  <= neg_reg[k-1];
            ovf_reg[k]  <= ovf_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign quo_neg   = neg_reg[QUO_W];
    assign quo_ovf   = ovf_reg[QUO_W];
    assign quo_mag   = sh_reg[QUO_W];
    assign side_out  = side_reg[QUO_W];

endmodule

// File: rtl/core/pinhole_reprojection_jacobian_core.sv
// top level: pinhole reprojection error and point jacobian pipeline
//
// channel   | handshake            | payload
// ----------+----------------------+----------------------------------------------
// config    | cfg_we               | cfg_addr, cfg_wdata (focal_x/y, center_x/y)
// item in   | start & !busy        | point_*, quat_*, trans_*, meas_u, meas_v
// result    | done (one cycle)     | err_u, err_v, jac_*, depth_positive
//
// one transfer in per cycle; busy never rises
// done rises after the accepting edge once the item has passed the front stages and
// the two bit-per-stage divider chains (projection/h, then jacobian)
// reset clears all valid bits and the intrinsics registers
// the receiver cannot stall; each result appears on done for one cycle
module pinhole_reprojection_jacobian_core #(
    parameter int FRAC_BITS = prj_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [prj_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [prj_pkg::DATA_W-1:0]            cfg_wdata,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [prj_pkg::DATA_W-1:0]     point_x,
    input  logic signed [prj_pkg::DATA_W-1:0]     point_y,
    input  logic signed [prj_pkg::DATA_W-1:0]     point_z,
    input  logic signed [prj_pkg::DATA_W-1:0]     quat_w,
    input  logic signed [prj_pkg::DATA_W-1:0]     quat_x,
    input  logic signed [prj_pkg::DATA_W-1:0]     quat_y,
    input  logic signed [prj_pkg::DATA_W-1:0]     quat_z,
    input  logic signed [prj_pkg::DATA_W-1:0]     trans_x,
    input  logic signed [prj_pkg::DATA_W-1:0]     trans_y,
    input  logic signed [prj_pkg::DATA_W-1:0]     trans_z,
    input  logic signed [prj_pkg::DATA_W-1:0]     meas_u,
    input  logic signed [prj_pkg::DATA_W-1:0]     meas_v,
    output logic                                  done,
    output logic signed [prj_pkg::DATA_W-1:0]     err_u,
    output logic signed [prj_pkg::DATA_W-1:0]     err_v,
    output logic signed [prj_pkg::DATA_W-1:0]     jac_u_x,
    output logic signed [prj_pkg::DATA_W-1:0]     jac_u_y,
    output logic signed [prj_pkg::DATA_W-1:0]     jac_u_z,
    output logic signed [prj_pkg::DATA_W-1:0]     jac_v_x,
    output logic signed [prj_pkg::DATA_W-1:0]     jac_v_y,
    output logic signed [prj_pkg::DATA_W-1:0]     jac_v_z,
    output logic                                  depth_positive
);
    import prj_pkg::*;

    localparam int W       = DATA_W;
    localparam int PR_W    = 2 * DATA_W;           // signed 32 x signed 32
    localparam int WIDE_W  = 44;                   // headroom for sums before saturation
    localparam int NH_W    = DIFF_W + FRAC_BITS;   // scaled jacobian numerator
    localparam int CLAMP_W = QUO1_W + 1;
    localparam int SIDE1_W = 3 * DATA_W + 2;
    localparam int SIDE2_W = 2 * DATA_W + 2;

    localparam logic signed [WIDE_W-1:0]  ONE_Q    = WIDE_W'(64'sd1 <<< QUAT_FRAC);
    localparam logic signed [WIDE_W-1:0]  S32_MAX  = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0]  S32_MIN  = WIDE_W'(-64'sd2147483648);
    localparam logic [QUO1_W-1:0]         MAG_PMAX = QUO1_W'(64'h7FFFFFFF);
    localparam logic [QUO1_W-1:0]         MAG_NMAX = QUO1_W'(64'h80000000);
    localparam logic [QUO1_W-1:0]         MAG_LIM  = QUO1_W'(64'd1 << 40);

    // saturate a wide signed value to 32 bits
    function automatic logic signed [W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [W-1:0] r;
        if (v > S32_MAX)
            r = W'(S32_MAX);
        else if (v < S32_MIN)
            r = W'(S32_MIN);
        else
            r = W'(v);
        return r;
    endfunction

    // sign-magnitude quotient to saturated 32-bit value
    function automatic logic signed [W-1:0] quo_sat(input logic neg, input logic ovf,
                                                   input logic [QUO1_W-1:0] mag);
        logic signed [W-1:0] r;
        if (!neg)
            r = (ovf || mag > MAG_PMAX) ? W'(S32_MAX) : $signed(W'(mag));
        else
            r = (ovf || mag > MAG_NMAX) ? W'(S32_MIN) : -$signed(W'(mag));
        return r;
    endfunction

    // sign-magnitude quotient clamped to plus or minus 2^40
    function automatic logic signed [CLAMP_W-1:0] quo_clamp(input logic neg, input logic ovf,
                                                          input logic [QUO1_W-1:0] mag);
        logic [QUO1_W-1:0] m;
        m = (ovf || mag > MAG_LIM) ? MAG_LIM : mag;
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // ---------------- intrinsics registers ----------------
    logic [W-1:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= '0;
            focal_y_reg  <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FOCAL_X:  focal_x_reg  <= cfg_wdata;
                REG_FOCAL_Y:  focal_y_reg  <= cfg_wdata;
                REG_CENTER_X: center_x_reg <= cfg_wdata;
                REG_CENTER_Y: center_y_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // fully pipelined, accepts every cycle
    assign busy = 1'b0;

    logic in_go;
    assign in_go = start & ~busy;

    // ---------------- valid chain for the front stages ----------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic s7_vld_reg, s8_vld_reg, s9_vld_reg;
    logic d1_vld, d2_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
            s9_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_go;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= d1_vld;
            s8_vld_reg <= s7_vld_reg;
            s9_vld_reg <= d2_vld;
        end
    end

    // ---------------- stage 1: quaternion pair products ----------------
    logic signed [PR_W-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [PR_W-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [W-1:0]    pnt1_reg [3];
    logic signed [W-1:0]    trn1_reg [3];
    logic signed [W-1:0]    mu1_reg, mv1_reg;

    always_ff @(posedge clk)
    begin
        xx_reg      <= quat_x * quat_x;
        yy_reg      <= quat_y * quat_y;
        zz_reg      <= quat_z * quat_z;
        xy_reg      <= quat_x * quat_y;
        xz_reg      <= quat_x * quat_z;
        yz_reg      <= quat_y * quat_z;
        wx_reg      <= quat_w * quat_x;
        wy_reg      <= quat_w * quat_y;
        wz_reg      <= quat_w * quat_z;
        pnt1_reg[0] <= point_x;
        pnt1_reg[1] <= point_y;
        pnt1_reg[2] <= point_z;
        trn1_reg[0] <= trans_x;
        trn1_reg[1] <= trans_y;
        trn1_reg[2] <= trans_z;
        mu1_reg     <= meas_u;
        mv1_reg     <= meas_v;
    end

    // ---------------- stage 2: rotation matrix ----------------
    // each pair product shifted by 29 gives 2ab in Q2.30
    logic signed [WIDE_W-1:0] txx, tyy, tzz, txy, txz, tyz, twx, twy, twz;
    logic signed [W-1:0]      rot_next [9];
    logic signed [W-1:0]      rot2_reg [9];
    logic signed [W-1:0]      pnt2_reg [3];
    logic signed [W-1:0]      trn2_reg [3];
    logic signed [W-1:0]      mu2_reg, mv2_reg;

    assign txx = WIDE_W'(xx_reg >>> (QUAT_FRAC - 1));
    assign tyy = WIDE_W'(yy_reg >>> (QUAT_FRAC - 1));
    assign tzz = WIDE_W'(zz_reg >>> (QUAT_FRAC - 1));
    assign txy = WIDE_W'(xy_reg >>> (QUAT_FRAC - 1));
    assign txz = WIDE_W'(xz_reg >>> (QUAT_FRAC - 1));
    assign tyz = WIDE_W'(yz_reg >>> (QUAT_FRAC - 1));
    assign twx = WIDE_W'(wx_reg >>> (QUAT_FRAC - 1));
    assign twy = WIDE_W'(wy_reg >>> (QUAT_FRAC - 1));
    assign twz = WIDE_W'(wz_reg >>> (QUAT_FRAC - 1));

    always_comb
    begin
        rot_next[0] = sat32(ONE_Q - (tyy + tzz));
        rot_next[1] = sat32(txy - twz);
        rot_next[2] = sat32(txz + twy);
        rot_next[3] = sat32(txy + twz);
        rot_next[4] = sat32(ONE_Q - (txx + tzz));
        rot_next[5] = sat32(tyz - twx);
        rot_next[6] = sat32(txz - twy);
        rot_next[7] = sat32(tyz + twx);
        rot_next[8] = sat32(ONE_Q - (txx + tyy));
    end

    always_ff @(posedge clk)
    begin
        rot2_reg <= rot_next;
        pnt2_reg <= pnt1_reg;
        trn2_reg <= trn1_reg;
        mu2_reg  <= mu1_reg;
        mv2_reg  <= mv1_reg;
    end

    // ---------------- stage 3: rotation times point ----------------
    logic signed [PR_W-1:0] prc3_reg [9];
    logic signed [W-1:0]    rot3_reg [9];
    logic signed [W-1:0]    trn3_reg [3];
    logic signed [W-1:0]    mu3_reg, mv3_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            prc3_reg[i] <= rot2_reg[i] * pnt2_reg[i % 3];
        end
        rot3_reg <= rot2_reg;
        trn3_reg <= trn2_reg;
        mu3_reg  <= mu2_reg;
        mv3_reg  <= mv2_reg;
    end

    // ---------------- stage 4: camera point ----------------
    logic signed [W-1:0] cam_next [3];
    logic signed [W-1:0] cam4_reg [3];
    logic signed [W-1:0] rot4_reg [9];
    logic signed [W-1:0] mu4_reg, mv4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cam_next[i] = sat32(WIDE_W'(trn3_reg[i])
                              + WIDE_W'(prc3_reg[3*i]   >>> QUAT_FRAC)
                              + WIDE_W'(prc3_reg[3*i+1] >>> QUAT_FRAC)
                              + WIDE_W'(prc3_reg[3*i+2] >>> QUAT_FRAC));
        end
    end

    always_ff @(posedge clk)
    begin
        cam4_reg <= cam_next;
        rot4_reg <= rot3_reg;
        mu4_reg  <= mu3_reg;
        mv4_reg  <= mv3_reg;
    end

    // ---------------- stage 5: projection and jacobian products ----------------
    // mcr: c_r * R[2][k], mcz: c_z * R[r][k], row-major over (r, k)
    logic signed [PROD_W-1:0] nu5_reg, nv5_reg;
    logic signed [PR_W-1:0]   mcr5_reg [6];
    logic signed [PR_W-1:0]   mcz5_reg [6];
    logic signed [W-1:0]      cz5_reg, mu5_reg, mv5_reg;

    always_ff @(posedge clk)
    begin
        nu5_reg <= $signed({1'b0, focal_x_reg}) * cam4_reg[0];
        nv5_reg <= $signed({1'b0, focal_y_reg}) * cam4_reg[1];
        for (int i = 0; i < 6; i++)
        begin
            mcr5_reg[i] <= cam4_reg[i / 3] * rot4_reg[6 + (i % 3)];
            mcz5_reg[i] <= cam4_reg[2] * rot4_reg[i];
        end
        cz5_reg <= cam4_reg[2];
        mu5_reg <= mu4_reg;
        mv5_reg <= mv4_reg;
    end

    // ---------------- stage 6: jacobian numerators ----------------
    logic signed [DIFF_W-1:0] dif_next [6];
    logic signed [NH_W-1:0]   nh6_reg  [6];
    logic signed [PROD_W-1:0] nu6_reg, nv6_reg;
    logic signed [W-1:0]      cz6_reg, mu6_reg, mv6_reg;
    logic                     zero6_reg, pos6_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            dif_next[i] = DIFF_W'(mcr5_reg[i] >>> QUAT_FRAC)
                        - DIFF_W'(mcz5_reg[i] >>> QUAT_FRAC);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            nh6_reg[i] <= NH_W'(dif_next[i]) <<< FRAC_BITS;
        end
        nu6_reg   <= nu5_reg;
        nv6_reg   <= nv5_reg;
        cz6_reg   <= cz5_reg;
        mu6_reg   <= mu5_reg;
        mv6_reg   <= mv5_reg;
        zero6_reg <= (cz5_reg == '0);
        pos6_reg  <= (cz5_reg > 0);
    end

    // ---------------- first divider bank: projection and h ----------------
    // measurement, depth and flags ride along the u divider
    logic                 qu_neg, qu_ovf, qv_neg, qv_ovf;
    logic [QUO1_W-1:0]    qu_mag, qv_mag;
    logic [SIDE1_W-1:0]   side1_out;
    logic                 h_neg [6];
    logic                 h_ovf [6];
    logic [QUO1_W-1:0]    h_mag [6];

    prj_div #(
        .NUM_W  (PROD_W),
        .QUO_W  (QUO1_W),
        .SIDE_W (SIDE1_W)
    ) u_div_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_vld_reg),
        .num       (nu6_reg),
        .den       (cz6_reg),
        .side_in   ({mu6_reg, mv6_reg, cz6_reg, zero6_reg, pos6_reg}),
        .out_valid (d1_vld),
        .quo_neg   (qu_neg),
        .quo_ovf   (qu_ovf),
        .quo_mag   (qu_mag),
        .side_out  (side1_out)
    );

    prj_div #(
        .NUM_W  (PROD_W),
        .QUO_W  (QUO1_W),
        .SIDE_W (1)
    ) u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_vld_reg),
        .num       (nv6_reg),
        .den       (cz6_reg),
        .side_in   (1'b0),
        .out_valid (),
        .quo_neg   (qv_neg),
        .quo_ovf   (qv_ovf),
        .quo_mag   (qv_mag),
        .side_out  ()
    );

    for (genvar g = 0; g < 6; g++)
    begin : g_div_h
        prj_div #(
            .NUM_W  (NH_W),
            .QUO_W  (QUO1_W),
            .SIDE_W (1)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s6_vld_reg),
            .num       (nh6_reg[g]),
            .den       (cz6_reg),
            .side_in   (1'b0),
            .out_valid (),
            .quo_neg   (h_neg[g]),
            .quo_ovf   (h_ovf[g]),
            .quo_mag   (h_mag[g]),
            .side_out  ()
        );
    end

    // ---------------- stage 7: error and saturated h ----------------
    logic signed [W-1:0]       mu_d1, mv_d1, cz_d1;
    logic                      zero_d1, pos_d1;
    logic signed [CLAMP_W-1:0] qu_clamped, qv_clamped;
    logic signed [W-1:0]       eu7_reg, ev7_reg, cz7_reg;
    logic signed [W-1:0]       h7_reg [6];
    logic                      zero7_reg, pos7_reg;

    assign {mu_d1, mv_d1, cz_d1, zero_d1, pos_d1} = side1_out;
    assign qu_clamped = quo_clamp(qu_neg, qu_ovf, qu_mag);
    assign qv_clamped = quo_clamp(qv_neg, qv_ovf, qv_mag);

    always_ff @(posedge clk)
    begin
        eu7_reg <= sat32(WIDE_W'(mu_d1) - WIDE_W'(qu_clamped)
                       - $signed(WIDE_W'(center_x_reg)));
        ev7_reg <= sat32(WIDE_W'(mv_d1) - WIDE_W'(qv_clamped)
                       - $signed(WIDE_W'(center_y_reg)));
        for (int i = 0; i < 6; i++)
        begin
            h7_reg[i] <= quo_sat(h_neg[i], h_ovf[i], h_mag[i]);
        end
        cz7_reg   <= cz_d1;
        zero7_reg <= zero_d1;
        pos7_reg  <= pos_d1;
    end

    // ---------------- stage 8: focal times h ----------------
    logic signed [PROD_W-1:0] jn8_reg [6];
    logic signed [W-1:0]      eu8_reg, ev8_reg, cz8_reg;
    logic                     zero8_reg, pos8_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            jn8_reg[i]     <= $signed({1'b0, focal_x_reg}) * h7_reg[i];
            jn8_reg[i + 3] <= $signed({1'b0, focal_y_reg}) * h7_reg[i + 3];
        end
        eu8_reg   <= eu7_reg;
        ev8_reg   <= ev7_reg;
        cz8_reg   <= cz7_reg;
        zero8_reg <= zero7_reg;
        pos8_reg  <= pos7_reg;
    end

    // ---------------- second divider bank: jacobian ----------------
    logic               j_neg [6];
    logic               j_ovf [6];
    logic [QUO2_W-1:0]  j_mag [6];
    logic [SIDE2_W-1:0] side2_out;

    prj_div #(
        .NUM_W  (PROD_W),
        .QUO_W  (QUO2_W),
        .SIDE_W (SIDE2_W)
    ) u_div_j0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s8_vld_reg),
        .num       (jn8_reg[0]),
        .den       (cz8_reg),
        .side_in   ({eu8_reg, ev8_reg, zero8_reg, pos8_reg}),
        .out_valid (d2_vld),
        .quo_neg   (j_neg[0]),
        .quo_ovf   (j_ovf[0]),
        .quo_mag   (j_mag[0]),
        .side_out  (side2_out)
    );

    for (genvar g = 1; g < 6; g++)
    begin : g_div_j
        prj_div #(
            .NUM_W  (PROD_W),
            .QUO_W  (QUO2_W),
            .SIDE_W (1)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s8_vld_reg),
            .num       (jn8_reg[g]),
            .den       (cz8_reg),
            .side_in   (1'b0),
            .out_valid (),
            .quo_neg   (j_neg[g]),
            .quo_ovf   (j_ovf[g]),
            .quo_mag   (j_mag[g]),
            .side_out  ()
        );
    end

    // ---------------- stage 9: output registers ----------------
    // zero depth forces error and jacobian to zero
    logic signed [W-1:0] eu_d2, ev_d2;
    logic                zero_d2, pos_d2;
    logic signed [W-1:0] eu9_reg, ev9_reg;
    logic signed [W-1:0] j9_reg [6];
    logic                pos9_reg;

    assign {eu_d2, ev_d2, zero_d2, pos_d2} = side2_out;

    always_ff @(posedge clk)
    begin
        eu9_reg <= zero_d2 ? '0 : eu_d2;
        ev9_reg <= zero_d2 ? '0 : ev_d2;
        for (int i = 0; i < 6; i++)
        begin
            j9_reg[i] <= zero_d2 ? '0 : quo_sat(j_neg[i], j_ovf[i], QUO1_W'(j_mag[i]));
        end
        pos9_reg <= pos_d2;
    end

    assign done           = s9_vld_reg;
    assign err_u          = eu9_reg;
    assign err_v          = ev9_reg;
    assign jac_u_x        = j9_reg[0];
    assign jac_u_y        = j9_reg[1];
    assign jac_u_z        = j9_reg[2];
    assign jac_v_x        = j9_reg[3];
    assign jac_v_y        = j9_reg[4];
    assign jac_v_z        = j9_reg[5];
    assign depth_positive = pos9_reg;

endmodule

// File: tb/sv/tb_pinhole_reprojection_jacobian_core.sv
// testbench for the pinhole reprojection error and point jacobian core
`timescale 1ns / 100ps

module tb_pinhole_reprojection_jacobian_core;
    import prj_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int LATENCY    = QUO1_W + QUO2_W + 10;
    localparam int WDOG_LIMIT = 4000;
    localparam int N_RANDOM   = 1530;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // one input transfer
    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [31:0] qw, qx, qy, qz;
        logic signed [31:0] tx, ty, tz;
        logic signed [31:0] mu, mv;
    } obs_t;

    // one result transfer
    typedef struct packed {
        logic signed [31:0] eu, ev;
        logic signed [31:0] jux, juy, juz, jvx, jvy, jvz;
        logic               dpos;
    } resid_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;
    logic start = 1'b0;
    logic busy;
    obs_t obs_in = '0;
    logic done;
    resid_t resid_out;

    always #5 clk = ~clk;

    pinhole_reprojection_jacobian_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy),
        .point_x(obs_in.px), .point_y(obs_in.py), .point_z(obs_in.pz),
        .quat_w(obs_in.qw), .quat_x(obs_in.qx), .quat_y(obs_in.qy), .quat_z(obs_in.qz),
        .trans_x(obs_in.tx), .trans_y(obs_in.ty), .trans_z(obs_in.tz),
        .meas_u(obs_in.mu), .meas_v(obs_in.mv),
        .done(done),
        .err_u(resid_out.eu), .err_v(resid_out.ev),
        .jac_u_x(resid_out.jux), .jac_u_y(resid_out.juy), .jac_u_z(resid_out.juz),
        .jac_v_x(resid_out.jvx), .jac_v_y(resid_out.jvy), .jac_v_z(resid_out.jvz),
        .depth_positive(resid_out.dpos)
    );

    // predictor copy of the intrinsics
    longint focal_u, focal_v, center_u, center_v;

    resid_t pending_resid[$];
    int mismatch_count = 0;
    int idle_cycles = 0;

    // >>> on longint is arithmetic, so the predictor's shifts floor like the hardware shifts
    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip40(longint v);
        longint lim;
        lim = 64'sd1 <<< 40;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // twice a*b in Q2.30
    function automatic longint pair2(longint a, longint b);
        return (a * b) >>> (QUAT_FRAC - 1);
    endfunction

    function automatic longint jac_entry(longint f, longint cr, longint cz,
                                         longint r2k, longint rrk);
        longint d, h;
        d = ((cr * r2k) >>> QUAT_FRAC) - ((cz * rrk) >>> QUAT_FRAC);
        h = clip32((d * (64'sd1 <<< FRAC)) / cz);
        return clip32((f * h) / cz);
    endfunction

    // expected error, jacobian and depth flag for one observation
    function automatic resid_t predict_resid(obs_t o);
        longint w, x, y, z, one, s;
        longint rot[3][3];
        longint pt[3], tr[3], cam[3];
        longint qu, qv;
        resid_t r;
        w = o.qw; x = o.qx; y = o.qy; z = o.qz;
        one = 64'sd1 <<< QUAT_FRAC;
        pt[0] = o.px; pt[1] = o.py; pt[2] = o.pz;
        tr[0] = o.tx; tr[1] = o.ty; tr[2] = o.tz;
        rot[0][0] = clip32(one - (pair2(y, y) + pair2(z, z)));
        rot[0][1] = clip32(pair2(x, y) - pair2(w, z));
        rot[0][2] = clip32(pair2(x, z) + pair2(w, y));
        rot[1][0] = clip32(pair2(x, y) + pair2(w, z));
        rot[1][1] = clip32(one - (pair2(x, x) + pair2(z, z)));
        rot[1][2] = clip32(pair2(y, z) - pair2(w, x));
        rot[2][0] = clip32(pair2(x, z) - pair2(w, y));
        rot[2][1] = clip32(pair2(y, z) + pair2(w, x));
        rot[2][2] = clip32(one - (pair2(x, x) + pair2(y, y)));
        for (int i = 0; i < 3; i++)
        begin
            s = tr[i];
            for (int k = 0; k < 3; k++)
                s += (rot[i][k] * pt[k]) >>> QUAT_FRAC;
            cam[i] = clip32(s);
        end
        r = '0;
        // zero depth forces everything to zero
        if (cam[2] != 0)
        begin
            qu = clip40((focal_u * cam[0]) / cam[2]);
            qv = clip40((focal_v * cam[1]) / cam[2]);
            r.eu  = 32'(clip32(longint'(o.mu) - qu - center_u));
            r.ev  = 32'(clip32(longint'(o.mv) - qv - center_v));
            r.jux = 32'(jac_entry(focal_u, cam[0], cam[2], rot[2][0], rot[0][0]));
            r.juy = 32'(jac_entry(focal_u, cam[0], cam[2], rot[2][1], rot[0][1]));
            r.juz = 32'(jac_entry(focal_u, cam[0], cam[2], rot[2][2], rot[0][2]));
            r.jvx = 32'(jac_entry(focal_v, cam[1], cam[2], rot[2][0], rot[1][0]));
            r.jvy = 32'(jac_entry(focal_v, cam[1], cam[2], rot[2][1], rot[1][1]));
            r.jvz = 32'(jac_entry(focal_v, cam[1], cam[2], rot[2][2], rot[1][2]));
            r.dpos = cam[2] > 0;
        end
        return r;
    endfunction

    // result side: compare every done strobe with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_resid.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: %p", resid_out);
            end
            else
            begin
                resid_t exp_r;
                exp_r = pending_resid.pop_front();
                if (resid_out !== exp_r)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %p actual %p", exp_r, resid_out);
                end
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // write enable stays up across a burst; the caller drops it
    task automatic write_intrinsic(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_FOCAL_X:  focal_u = val;
            REG_FOCAL_Y:  focal_v = val;
            REG_CENTER_X: center_u = val;
            default:      center_v = val;
        endcase
    endtask

    task automatic load_intrinsics(input logic [31:0] fx, fy, cx, cy);
        write_intrinsic(REG_FOCAL_X, fx);
        write_intrinsic(REG_FOCAL_Y, fy);
        write_intrinsic(REG_CENTER_X, cx);
        write_intrinsic(REG_CENTER_Y, cy);
        cfg_we <= 1'b0;
    endtask

    // drive one observation, with a random gap first; start stays up across
    // back-to-back transfers
    task automatic send_obs(input obs_t o, input resid_t fixed_r, input bit use_fixed);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        obs_in <= o;
        do @(posedge clk); while (busy);
        pending_resid.push_back(use_fixed ? fixed_r : predict_resid(o));
    endtask

    task automatic drain_results;
        start <= 1'b0;
        while (pending_resid.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word;
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 16) - 8;
            3: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return $urandom;
        endcase
    endfunction

    // mostly near-unit quaternions, points in front of the camera
    function automatic obs_t rand_obs;
        obs_t o;
        o.px = 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
        o.py = 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
        o.pz = 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
        o.qw = 32'h3800_0000 + $urandom_range(0, 32'h0800_0000);
        o.qx = 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        o.qy = 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        o.qz = 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        if ($urandom_range(0, 1)) o.qw = -o.qw;
        o.tx = 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        o.ty = 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        o.tz = 32'h0050_0000 + $urandom_range(0, 32'h0100_0000);
        o.mu = $urandom_range(0, 32'h0800_0000);
        o.mv = $urandom_range(0, 32'h0800_0000);
        if ($urandom_range(0, 4) == 0)
        begin
            // noise: any value in any field
            o = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word()};
        end
        else if ($urandom_range(0, 9) == 0)
            o.tz = -o.tz;
        return o;
    endfunction

    // directed rows: stimulus plus an expectation where it is obvious
    typedef struct {
        obs_t   o;
        resid_t r;
        bit     fixed;
    } dir_row_t;

    dir_row_t dir_rows[$];

    initial
    begin
        obs_t o;
        dir_row_t row;
        focal_u = 0; focal_v = 0; center_u = 0; center_v = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // intrinsics still at reset: zero focal, so only the measurement survives
        o = '0;
        o.qw = ONE_Q30; o.tz = 32'h0001_0000; o.mu = 32'h0012_3456; o.mv = -32'sd77;
        row.o = o; row.r = '0; row.r.eu = o.mu; row.r.ev = o.mv; row.r.dpos = 1'b1;
        row.fixed = 1; dir_rows.push_back(row);
        // zero depth: all zero
        o.tz = '0;
        row.o = o; row.r = '0; row.fixed = 1; dir_rows.push_back(row);
        // zero quaternion, zero everything
        row.o = '0; row.r = '0; row.fixed = 1; dir_rows.push_back(row);
        foreach (dir_rows[i]) send_obs(dir_rows[i].o, dir_rows[i].r, 1);
        drain_results();
        dir_rows.delete();

        // typical camera
        load_intrinsics(32'h01F4_0000, 32'h01F4_0000, 32'h0140_0000, 32'h00F0_0000);
        o = '0; o.qw = ONE_Q30; o.px = 32'h0001_0000; o.pz = 32'h0005_0000;
        o.mu = 32'h0150_0000; o.mv = 32'h00F0_0000;
        for (int i = 0; i < 22; i++)
        begin
            row.fixed = 0; row.r = '0; row.o = o;
            case (i)
                1: row.o.tz = -32'sh0008_0000;                          // negative depth
                2: row.o.pz = '0;                                       // zero depth
                3: begin row.o.qw = 32'h7FFF_FFFF; row.o.qx = 32'h7FFF_FFFF; end
                4: begin row.o.qx = 32'h8000_0000; row.o.qy = 32'h8000_0000;
                         row.o.qz = 32'h8000_0000; row.o.qw = 32'h8000_0000; end
                5: begin row.o.px = 32'h7FFF_FFFF; row.o.py = 32'h8000_0000; end
                6: row.o.pz = 32'h7FFF_FFFF;
                7: row.o.pz = 32'h8000_0000;
                8: begin row.o.tx = 32'h7FFF_FFFF; row.o.ty = 32'h8000_0000; end
                9: row.o.tz = 32'h7FFF_FFFF;
                10: row.o.mu = 32'h7FFF_FFFF;
                11: row.o.mv = 32'h8000_0000;
                12: begin row.o.pz = 32'sd1; row.o.px = 32'h7FFF_FFFF; end  // tiny depth
                13: row.o.pz = -32'sd1;
                14: begin row.o.qw = '0; row.o.qz = ONE_Q30; end
                15: begin row.o.qw = '0; row.o.qy = ONE_Q30; end
                16: row.o = '1;
                default: row.o = rand_obs();
            endcase
            dir_rows.push_back(row);
        end
        foreach (dir_rows[i]) send_obs(dir_rows[i].o, dir_rows[i].r, 0);
        drain_results();

        // random part over several intrinsics settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: load_intrinsics(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                1: load_intrinsics(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
                2: load_intrinsics(32'h0258_0000, 32'h0258_0000, 32'h0190_0000, 32'h012C_0000);
                default: load_intrinsics($urandom_range(0, 32'h0800_0000),
                                         $urandom_range(0, 32'h0800_0000),
                                         $urandom, $urandom_range(0, 32'h0400_0000));
            endcase
            for (int n = 0; n < N_RANDOM / 6; n++)
            begin
                // stretches of back-to-back transfers
                if ((n / 40) % 3 == 0)
                begin
                    start <= 1'b1;
                    obs_in <= rand_obs();
                    @(posedge clk);
                    while (busy) @(posedge clk);
                    pending_resid.push_back(predict_resid(obs_in));
                end
                else
                    send_obs(rand_obs(), '0, 0);
            end
            drain_results();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && pending_resid.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/prj_pkg.sv
rtl/core/prj_div.sv
rtl/core/pinhole_reprojection_jacobian_core.sv
tb/sv/tb_pinhole_reprojection_jacobian_core.sv
